### hdl/pparp_pkg.sv
`timescale 1ns / 1ps
// Types, codes and frame helpers shared by the period meter modules.
package pparp_pkg;

  localparam int STAMP_W = 16;
  localparam int BYTE_W  = 8;
  localparam int TICK_W  = 8;

  // Item kinds on the input channel.
  localparam logic [1:0] FUNC_EDGE   = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  localparam logic [STAMP_W-1:0] EMPTY_PERIOD  = 16'hFFFF;
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 8'd50;

  localparam logic [BYTE_W-1:0] FRAME_HEAD0 = 8'h94;
  localparam logic [BYTE_W-1:0] FRAME_HEAD1 = 8'h81;
  localparam logic [6:0]        CHECK_SEED  = 7'h14 ^ 7'h01;
  localparam logic [BYTE_W-1:0] MARK_BIT    = 8'h80;

  localparam int FRAME_BYTES = 6;

  // Frame byte positions.
  localparam logic [2:0] POS_HEAD0 = 3'd0;
  localparam logic [2:0] POS_HEAD1 = 3'd1;
  localparam logic [2:0] POS_HIGH  = 3'd2;
  localparam logic [2:0] POS_MID   = 3'd3;
  localparam logic [2:0] POS_LOW   = 3'd4;
  localparam logic [2:0] POS_CHECK = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic [STAMP_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;
  } out_item_t;

  // Controls for the shared accumulate / scale unit.
  typedef struct packed {
    logic clear;
    logic acc;
    logic load;
  } alu_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DIV,
    S_SEND
  } state_t;

  function automatic logic [BYTE_W-1:0] frame_byte_f(input logic [2:0] pos,
                                                     input logic [STAMP_W-1:0] avg);
    logic [6:0] g_high;
    logic [6:0] g_mid;
    logic [6:0] g_low;
    logic [BYTE_W-1:0] res;
    g_high = {5'd0, avg[15:14]};
    g_mid  = avg[13:7];
    g_low  = avg[6:0];
    case (pos)
      POS_HEAD0: res = FRAME_HEAD0;
      POS_HEAD1: res = FRAME_HEAD1;
      POS_HIGH:  res = MARK_BIT | {1'b0, g_high};
      POS_MID:   res = MARK_BIT | {1'b0, g_mid};
      POS_LOW:   res = MARK_BIT | {1'b0, g_low};
      POS_CHECK: res = MARK_BIT | {1'b0, CHECK_SEED ^ g_high ^ g_mid ^ g_low};
      default:   res = FRAME_HEAD0;
    endcase
    return res;
  endfunction

endpackage

### hdl/pparp_history.sv
`timescale 1ns / 1ps
// Period history ring: memory, per-entry valid bits, write slot, registered read.
module pparp_history import pparp_pkg::*; #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [STAMP_W-1:0]               wr_data,
  input  logic                             clear,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
  output logic [STAMP_W-1:0]               rd_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

  logic [STAMP_W-1:0]       mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld;
  logic [AW-1:0]            slot;
  logic [STAMP_W-1:0]       mem_q;
  logic                     vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Entries never written since the last clear read as the empty period.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld   <= '0;
      slot  <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[rd_addr];
      if (wr_en) begin
        vld[slot] <= 1'b1;
        slot      <= (slot == LAST_SLOT) ? '0 : slot + AW'(1);
      end
    end
  end

  assign rd_data = vld_q ? mem_q : EMPTY_PERIOD;

endmodule

### hdl/pparp_alu.sv
`timescale 1ns / 1ps
// Shared adder for the history sum, then a constant reciprocal multiply for the average.
module pparp_alu import pparp_pkg::*; #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic               clk,
  input  alu_ctl_t           ctl,
  input  logic [STAMP_W-1:0] entry,
  output logic [STAMP_W-1:0] avg
);

  localparam int LW    = $clog2(HISTORY_DEPTH);
  localparam int SUMW  = STAMP_W + LW;
  localparam int SHIFT = SUMW + LW;
  localparam int MW    = SUMW + 1;
  localparam int PW    = SUMW + MW;
  // ceil(2^SHIFT / depth): exact floor division for every sum below 2^SUMW.
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(HISTORY_DEPTH - 1)) / 64'(HISTORY_DEPTH);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  logic [SUMW-1:0]    sum;
  logic [PW-1:0]      prod;
  logic [STAMP_W-1:0] quo;

  assign prod = PW'(sum) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum <= '0;
    end else if (ctl.acc) begin
      sum <= sum + SUMW'(entry);
    end
    if (ctl.load) begin
      quo <= prod[SHIFT +: STAMP_W];
    end
  end

  assign avg = quo;

endmodule

### hdl/pulse_period_average_reporter_top.sv
`timescale 1ns / 1ps
// Edge and tick items leave the block idle, so it stays ready for the next item.
// A report reads every history entry (S_READ), drains the last read (S_DRAIN) and
// scales (S_DIV) before its first beat, then sends six beats at one per cycle while ready.
// No item is accepted while a report is in progress.
// Synchronous reset empties the history, clears the stamps and counters and sets
// the timeout to 50 ticks; it takes effect at once, with no clearing pass.
module pulse_period_average_reporter_top import pparp_pkg::*; #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  // The counter walks the history addresses.
  localparam logic [AW-1:0] LAST_READ = AW'(HISTORY_DEPTH - 1);
  localparam logic [2:0]    LAST_POS  = 3'(FRAME_BYTES - 1);

  state_t state;
  state_t state_next;

  logic [AW-1:0]      cnt;
  logic [2:0]         pos;
  logic               rd_pend;
  logic [TICK_W-1:0]  timeout_ticks;
  logic [TICK_W-1:0]  idle_ticks;
  logic [TICK_W-1:0]  idle_inc;
  logic [STAMP_W-1:0] previous_stamp;
  logic               stamp_valid;

  logic               in_fire;
  logic               out_fire;
  logic               is_edge;
  logic               is_tick;
  logic               is_report;
  logic               timed_out;
  logic               hist_wr;
  logic               hist_clear;
  logic [STAMP_W-1:0] period;
  logic [STAMP_W-1:0] entry;
  logic [STAMP_W-1:0] avg;
  alu_ctl_t           ctl;

  // Handshakes and item decode.
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign is_edge   = in_fire && (in_item.func == FUNC_EDGE);
  assign is_tick   = in_fire && (in_item.func == FUNC_TICK);
  assign is_report = in_fire && (in_item.func == FUNC_REPORT);

  // Idle counter is eight bits wide; reaching the timeout restarts it, and when an
  // edge has been seen the whole history is dropped as well.
  assign idle_inc   = idle_ticks + TICK_W'(1);
  assign timed_out  = is_tick && (idle_inc >= timeout_ticks);
  assign hist_clear = timed_out && stamp_valid;
  assign hist_wr    = is_edge && stamp_valid;
  assign period     = in_item.timestamp - previous_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks     <= '0;
      previous_stamp <= '0;
      stamp_valid    <= 1'b0;
    end else begin
      if (is_edge) begin
        previous_stamp <= in_item.timestamp;
        stamp_valid    <= 1'b1;
        idle_ticks     <= '0;
      end else if (is_tick) begin
        idle_ticks <= timed_out ? '0 : idle_inc;
        if (hist_clear) begin
          stamp_valid <= 1'b0;
        end
      end
    end
  end

  // Report sequencer: read the ring, drain the last read, scale, send the frame.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (is_report) state_next = S_READ;
      S_READ:  if (cnt == LAST_READ) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DIV;
      S_DIV:   state_next = S_SEND;
      S_SEND:  if (out_fire && (pos == LAST_POS)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctl       = '0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctl.clear = is_report;
      end
      S_READ:  ctl.acc = rd_pend;
      S_DRAIN: ctl.acc = rd_pend;
      S_DIV:   ctl.load = 1'b1;
      S_SEND:  out_valid = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      pos     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      // Read data lands in the cycle after the address is issued.
      rd_pend <= (state == S_READ);
      cnt     <= (state_next != state) ? '0 : cnt + AW'(1);
      if (state != S_SEND) begin
        pos <= '0;
      end else if (out_fire) begin
        pos <= pos + 3'd1;
      end
    end
  end

  pparp_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (hist_wr),
    .wr_data (period),
    .clear   (hist_clear),
    .rd_addr (cnt),
    .rd_data (entry)
  );

  pparp_alu #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_alu (
    .clk   (clk),
    .ctl   (ctl),
    .entry (entry),
    .avg   (avg)
  );

  // Frame bytes come straight from the held average and the byte position.
  assign out_item.frame_byte = frame_byte_f(pos, avg);
  assign out_item.frame_last = (pos == LAST_POS);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pulse period average reporter.
module tb_top;
  import pparp_pkg::*;

  localparam int RING_DEPTH   = 8;
  // Edge and tick items need no sequencing and owed report beats drain first,
  // so these margins cover any work still in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 64;
  localparam int MAX_REPORTED  = 10;
  // func code 3 is not an item kind; the block must drop it silently.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  pulse_period_average_reporter_top #(
    .HISTORY_DEPTH(RING_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shadow state of the meter: period ring, write slot, last stamp, first-edge
  // flag, idle tick counter and the programmed timeout.
  // --------------------------------------------------------------------------
  logic [STAMP_W-1:0] period_ring [RING_DEPTH];
  int                 ring_slot;
  logic [STAMP_W-1:0] last_stamp;
  logic               have_stamp;
  logic [TICK_W-1:0]  idle_count;
  logic [TICK_W-1:0]  timeout_limit;

  // Frame beats still owed by the block, oldest first.
  out_item_t frame_expect [$];

  int mismatches;
  int beats_checked;
  int items_sent;
  int edges_sent;
  int ticks_sent;
  int reports_sent;
  int history_clears;
  int cfg_writes;

  // Shared between the stimulus and the receiver process.
  int hold_request;
  bit steady;

  // Refill the ring with empty periods and forget the previous edge.
  function automatic void clear_ring();
    for (int i = 0; i < RING_DEPTH; i++) period_ring[i] = EMPTY_PERIOD;
    ring_slot  = 0;
    have_stamp = 1'b0;
  endfunction

  // Apply one accepted input beat to the shadow state and queue the frame
  // bytes that a report owes.
  function automatic void track_item(in_item_t beat);
    logic [STAMP_W+2:0] sum;
    logic [STAMP_W-1:0] avg;
    logic [6:0]         g_high;
    logic [6:0]         g_mid;
    logic [6:0]         g_low;
    logic [BYTE_W-1:0]  frame [FRAME_BYTES];
    out_item_t          want;
    case (beat.func)
      FUNC_EDGE: begin
        if (have_stamp) begin
          // modulo 2^16 difference: wraps on a timer rollover
          period_ring[ring_slot] = beat.timestamp - last_stamp;
          ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
        end else begin
          have_stamp = 1'b1;
        end
        last_stamp = beat.timestamp;
        idle_count = '0;
      end
      FUNC_TICK: begin
        idle_count = idle_count + 8'd1;
        // a zero timeout is reached by every tick
        if (idle_count >= timeout_limit) begin
          idle_count = '0;
          if (have_stamp) begin
            clear_ring();
            history_clears++;
          end
        end
      end
      FUNC_REPORT: begin
        sum = '0;
        for (int i = 0; i < RING_DEPTH; i++) sum = sum + period_ring[i];
        avg    = STAMP_W'(sum / RING_DEPTH);
        g_high = {5'd0, avg[15:14]};
        g_mid  = avg[13:7];
        g_low  = avg[6:0];
        frame[0] = FRAME_HEAD0;
        frame[1] = FRAME_HEAD1;
        frame[2] = MARK_BIT | {1'b0, g_high};
        frame[3] = MARK_BIT | {1'b0, g_mid};
        frame[4] = MARK_BIT | {1'b0, g_low};
        frame[5] = MARK_BIT | {1'b0, CHECK_SEED ^ g_high ^ g_mid ^ g_low};
        for (int k = 0; k < FRAME_BYTES; k++) begin
          want.frame_byte = frame[k];
          want.frame_last = (k == FRAME_BYTES - 1);
          frame_expect.push_back(want);
        end
      end
      default: ;
    endcase
  endfunction

  // Sender gaps: mostly none or short, a few long; none in steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Far beyond the slowest legal run: every report waiting out long stalls.
  initial begin
    #5ms;
    $display("timeout: %0d frame beats still owed", frame_expect.size());
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, occasional long ones, and a counted hold-off on
  // request so that the block fills up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        out_ready <= 1'b0;
        for (int n = 0; n < hold; n++) @(posedge clk);
        hold_request = 0;
      end else if (!steady && $urandom_range(0, 39) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 3) != 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each output beat with the oldest owed frame byte.
  // --------------------------------------------------------------------------
  out_item_t owed;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_checked++;
      if (frame_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: unexpected beat byte=%02h last=%0b", $realtime,
                   out_item.frame_byte, out_item.frame_last);
      end else begin
        owed = frame_expect.pop_front();
        if (out_item.frame_byte !== owed.frame_byte ||
            out_item.frame_last !== owed.frame_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("%0t: beat mismatch expected byte=%02h last=%0b, got byte=%02h last=%0b",
                     $realtime, owed.frame_byte, owed.frame_last,
                     out_item.frame_byte, out_item.frame_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks
  // --------------------------------------------------------------------------

  // Offer one beat and hold it until accepted. Valid stays high when no gap
  // follows, so back-to-back beats never toggle it within one step.
  task automatic send_item(input logic [1:0] kind, input logic [STAMP_W-1:0] stamp);
    in_item_t beat;
    int       gap;
    beat.func      = kind;
    beat.timestamp = stamp;
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk); while (!in_ready);
    track_item(beat);
    items_sent++;
    case (kind)
      FUNC_EDGE:   edges_sent++;
      FUNC_TICK:   ticks_sent++;
      FUNC_REPORT: reports_sent++;
      default: ;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait until every owed beat has arrived, then let any edge or
  // tick still in flight finish.
  task automatic wait_drained(input int margin);
    in_valid <= 1'b0;
    while (frame_expect.size() != 0) @(posedge clk);
    repeat (margin) @(posedge clk);
  endtask

  // Program the timeout; only called with the block idle.
  task automatic set_timeout(input logic [TICK_W-1:0] value);
    wait_drained(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_limit = value;
    cfg_writes++;
  endtask

  // A train of edges at a steady period with small jitter, safe ticks in
  // between that never reach the timeout, then a report.
  task automatic send_pulse_train();
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] period;
    int                 n_edges;
    int                 r;
    stamp = STAMP_W'($urandom_range(0, 65535));
    r = $urandom_range(0, 9);
    if (r == 0)      period = '0;
    else if (r < 5)  period = STAMP_W'($urandom_range(1, 300));
    else if (r < 8)  period = STAMP_W'($urandom_range(300, 20000));
    else             period = STAMP_W'($urandom_range(20000, 65535));
    n_edges = $urandom_range(2, 11);
    for (int i = 0; i < n_edges; i++) begin
      send_item(FUNC_EDGE, stamp);
      stamp = stamp + period + STAMP_W'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0 && idle_count + 9'd1 < {1'b0, timeout_limit})
        send_item(FUNC_TICK, STAMP_W'($urandom_range(0, 65535)));
    end
    send_item(FUNC_REPORT, STAMP_W'($urandom_range(0, 65535)));
  endtask

  // Tick until the idle counter wraps back to zero at the timeout; with a
  // long timeout only a few ticks go out. A report follows half the time.
  task automatic send_idle_run();
    int n;
    if (timeout_limit > 12) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_item(FUNC_TICK, STAMP_W'($urandom_range(0, 65535)));
    end else begin
      do send_item(FUNC_TICK, STAMP_W'($urandom_range(0, 65535)));
      while (idle_count != 0);
    end
    if ($urandom_range(0, 1) == 0) send_item(FUNC_REPORT, STAMP_W'($urandom_range(0, 65535)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, every kind, wrap of the stamp difference, timeout with and
  // without a seen edge, one-tick and zero timeouts.
  task automatic test_directed();
    send_item(FUNC_REPORT, 16'h0000);     // empty history averages to all ones
    send_item(FUNC_UNUSED, 16'hFFFF);     // dropped, no frame
    send_item(FUNC_EDGE,   16'h0000);     // first edge only records
    send_item(FUNC_REPORT, 16'hFFFF);
    send_item(FUNC_EDGE,   16'hFFFF);
    send_item(FUNC_EDGE,   16'h0000);     // difference wraps to one
    send_item(FUNC_EDGE,   16'hAAAA);
    send_item(FUNC_EDGE,   16'h5555);     // negative step wraps
    send_item(FUNC_EDGE,   16'h5555);     // zero period
    send_item(FUNC_REPORT, 16'h0000);
    send_item(FUNC_TICK,   16'h0000);
    send_item(FUNC_TICK,   16'hFFFF);
    send_item(FUNC_REPORT, 16'h0000);
    set_timeout(8'd1);
    send_item(FUNC_TICK,   16'h0000);     // timeout with an edge seen: clear
    send_item(FUNC_REPORT, 16'h0000);
    send_item(FUNC_TICK,   16'h0000);     // timeout without an edge: count only
    send_item(FUNC_EDGE,   16'h8000);
    send_item(FUNC_EDGE,   16'h8001);
    send_item(FUNC_EDGE,   16'h7FFF);
    send_item(FUNC_REPORT, 16'h0000);
    set_timeout(8'd0);
    send_item(FUNC_TICK,   16'h0000);     // zero timeout: every tick reaches it
    send_item(FUNC_EDGE,   16'h1234);
    send_item(FUNC_TICK,   16'h0000);
    send_item(FUNC_REPORT, 16'h0000);
  endtask

  // Hold the receiver off for a long counted stretch while reports keep
  // coming, then pause the sender until every owed beat has drained.
  task automatic test_backpressure();
    set_timeout(8'd255);
    steady = 1'b1;
    hold_request = 200;
    send_item(FUNC_EDGE, 16'h0100);
    send_item(FUNC_EDGE, 16'h0200);
    for (int i = 0; i < 4; i++) send_item(FUNC_REPORT, STAMP_W'($urandom_range(0, 65535)));
    send_item(FUNC_EDGE, 16'h0280);
    steady = 1'b0;
    wait_drained(SETTLE_CYCLES);
    send_item(FUNC_REPORT, 16'h0000);
    send_item(FUNC_EDGE, 16'h0300);
    send_item(FUNC_REPORT, 16'h0000);
  endtask

  // Mostly well-formed pulse trains with random content, some idle runs (to the
  // timeout when it is short), and some noise, over several timeout settings.
  task automatic test_random();
    logic [TICK_W-1:0] limits [5];
    int                target;
    int                r;
    limits[0] = 8'd255;
    limits[1] = TICK_W'($urandom_range(2, 6));
    limits[2] = TICK_W'($urandom_range(1, 255));
    limits[3] = 8'd1;
    limits[4] = TIMEOUT_RESET;
    for (int p = 0; p < 5; p++) begin
      set_timeout(limits[p]);
      steady = (p == 1);
      target = items_sent + 12;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 65) send_pulse_train();
        else if (r < 85) send_idle_run();
        else send_item(2'($urandom_range(0, 3)), STAMP_W'($urandom_range(0, 65535)));
      end
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches     = 0;
    beats_checked  = 0;
    items_sent     = 0;
    edges_sent     = 0;
    ticks_sent     = 0;
    reports_sent   = 0;
    history_clears = 0;
    cfg_writes     = 0;
    hold_request   = 0;
    steady         = 1'b0;
    clear_ring();
    last_stamp    = '0;
    idle_count    = '0;
    timeout_limit = TIMEOUT_RESET;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random();

    wait_drained(END_CYCLES);
    if (frame_expect.size() != 0) begin
      mismatches++;
      $display("%0d frame beats never arrived", frame_expect.size());
    end

    $display("covered %0d items: %0d edges, %0d ticks, %0d reports, %0d history clears",
             items_sent, edges_sent, ticks_sent, reports_sent, history_clears);
    $display("checked %0d frame beats over %0d timeout settings, %0d mismatches",
             beats_checked, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
